FILE: sv/dbt_pkg.sv
// Shared types and constants for the decimal to balanced ternary converter.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package dbt_pkg;

	localparam int TRIT_COUNT = 25;
	localparam int MAG_W      = 40;
	localparam int PROD_W     = MAG_W + 4;
	localparam int CHUNK_W    = 8;
	localparam int DIV_CHUNKS = MAG_W / CHUNK_W;
	localparam int CHUNK_CNT_W = $clog2(DIV_CHUNKS);
	localparam int CNT_W      = $clog2(TRIT_COUNT + 1);
	localparam int IDX_W      = $clog2(TRIT_COUNT);

	localparam logic [7:0] CHAR_MINUS = 8'd45;
	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_ONE   = 8'd49;
	localparam logic [7:0] CHAR_NINE  = 8'd57;

	localparam logic [1:0] TRIT_ZERO = 2'b00;
	localparam logic [1:0] TRIT_POS  = 2'b01;
	localparam logic [1:0] TRIT_NEG  = 2'b11;

	localparam logic [63:0] MAG_MAX = 64'hFF_FFFF_FFFF;

	// largest magnitude that fits in TRIT_COUNT balanced trits, capped to the register
	function automatic logic [63:0] range_cap_f();
		logic [63:0] p;
		p = 64'd1;
		for (int i = 0; i < TRIT_COUNT; i++) begin
			p = p * 64'd3;
		end
		p = (p - 64'd1) / 64'd2;
		return (p < MAG_MAX) ? p : MAG_MAX;
	endfunction

	localparam logic [MAG_W-1:0] MAG_CAP = MAG_W'(range_cap_f());

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_STORE,
		ST_EMIT
	} state_t;

	// number state after the current character has been applied
	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic             neg;
		logic             bad;
		logic             ignored;
	} acc_t;

endpackage

`default_nettype wire

FILE: sv/dbt_accum.sv
// Character parser and decimal accumulator with range check.
// Depends on dbt_pkg.
`default_nettype none

module dbt_accum import dbt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [7:0] character,
	input  wire logic       final_char,
	output acc_t            nxt
);

	logic [MAG_W-1:0] mag_q;
	logic             neg_q;
	logic             bad_q;
	logic             first_seen_q;
	logic             zero_lead_q;
	logic             ignored_q;

	logic [MAG_W-1:0]  mag_d;
	logic              neg_d;
	logic              bad_d;
	logic              zero_lead_d;
	logic              ignored_d;
	logic              is_digit;
	logic [PROD_W-1:0] m10;
	logic              over;

	assign is_digit = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
	// m * 10 + d as two shifted copies plus the digit
	assign m10  = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0}
		+ PROD_W'(character[3:0]);
	assign over = m10 > PROD_W'(MAG_CAP);

	always_comb begin
		mag_d       = mag_q;
		neg_d       = neg_q;
		bad_d       = bad_q;
		zero_lead_d = zero_lead_q;
		ignored_d   = ignored_q;
		if (!first_seen_q) begin
			if (character == CHAR_MINUS) begin
				neg_d = 1'b1;
			end else if (character == CHAR_ZERO) begin
				zero_lead_d = 1'b1;
			end else if (character >= CHAR_ONE && character <= CHAR_NINE) begin
				if (over) bad_d = 1'b1;
				else mag_d = m10[MAG_W-1:0];
			end else if (character > CHAR_NINE) begin
				bad_d = 1'b1;
			end else begin
				ignored_d = 1'b1;
			end
		end else if (!zero_lead_q && !ignored_q) begin
			if (!is_digit) begin
				bad_d = 1'b1;
			end else if (!bad_q) begin
				if (over) bad_d = 1'b1;
				else mag_d = m10[MAG_W-1:0];
			end
		end
	end

	assign nxt.mag     = mag_d;
	assign nxt.neg     = neg_d;
	assign nxt.bad     = bad_d;
	assign nxt.ignored = ignored_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q        <= '0;
			neg_q        <= 1'b0;
			bad_q        <= 1'b0;
			first_seen_q <= 1'b0;
			zero_lead_q  <= 1'b0;
			ignored_q    <= 1'b0;
		end else if (take) begin
			if (final_char) begin
				// start the next number from scratch
				mag_q        <= '0;
				neg_q        <= 1'b0;
				bad_q        <= 1'b0;
				first_seen_q <= 1'b0;
				zero_lead_q  <= 1'b0;
				ignored_q    <= 1'b0;
			end else begin
				mag_q        <= mag_d;
				neg_q        <= neg_d;
				bad_q        <= bad_d;
				first_seen_q <= 1'b1;
				zero_lead_q  <= zero_lead_d;
				ignored_q    <= ignored_d;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/dbt_div3.sv
// Shared divide-by-3 step: one byte of dividend, MSB first, per cycle.
// Depends on dbt_pkg.
`default_nettype none

module dbt_div3 import dbt_pkg::*; (
	input  wire logic [CHUNK_W-1:0] chunk,
	input  wire logic [1:0]         rem_in,
	output logic [CHUNK_W-1:0]      quo,
	output logic [1:0]              rem_out
);

	always_comb begin
		logic [2:0] r;
		r   = {1'b0, rem_in};
		quo = '0;
		for (int i = CHUNK_W - 1; i >= 0; i--) begin
			r = {r[1:0], chunk[i]};
			if (r >= 3'd3) begin
				quo[i] = 1'b1;
				r      = r - 3'd3;
			end
		end
		rem_out = r[1:0];
	end

endmodule

`default_nettype wire

FILE: sv/decimal_to_balanced_ternary_unit.sv
// Top level: decimal text in, balanced ternary digits out, with sequencer and digit stack.
// Depends on dbt_pkg, dbt_accum and dbt_div3.
//
// Characters of a number are taken one per cycle. On the final character the block stops
// taking input and converts: each trit takes a zero check, one pass of the byte-wide
// divide-by-3 unit per byte of the 40-bit magnitude, and a step to round and push the
// trit. Then one digit leaves per cycle while the output is not stalled, most significant
// first; a number gives up to 25 trits. An error and a zero each give a single zero
// digit, and an ignored number gives none. The output register lets the next number
// start while the last digit still waits to be taken.
`default_nettype none

module decimal_to_balanced_ternary_unit import dbt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] character
	input  wire logic       s_tlast,   // final_char
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [1:0] trit, [7:2] zero
	output logic [0:0]      m_tuser,   // [0] status
	output logic            m_tlast    // run_end
);

	state_t state_q, state_d;

	logic [MAG_W-1:0]       work_q;
	logic [1:0]             rem_q;
	logic [CHUNK_CNT_W-1:0] chunk_q;
	logic [CNT_W-1:0]       count_q;
	logic [IDX_W-1:0]       rd_q;
	logic                   neg_q;
	logic                   single_q;
	logic                   err_q;
	logic [1:0]             trit_buf_q [TRIT_COUNT];

	logic       out_valid_q;
	logic [1:0] out_trit_q;
	logic       out_status_q;
	logic       out_last_q;

	logic                take;
	logic                out_load;
	logic                work_zero;
	logic                count_full;
	logic                last_chunk;
	logic [CHUNK_W-1:0]  quo;
	logic [1:0]          rem_nxt;
	logic [1:0]          new_trit;
	logic [1:0]          emit_trit;
	logic                emit_last;
	acc_t                acc;

	dbt_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.character  (s_tdata),
		.final_char (s_tlast),
		.nxt        (acc)
	);

	dbt_div3 u_div3 (
		.chunk   (work_q[MAG_W-1 -: CHUNK_W]),
		.rem_in  (rem_q),
		.quo     (quo),
		.rem_out (rem_nxt)
	);

	assign work_zero  = (work_q == '0);
	assign count_full = (count_q == CNT_W'(TRIT_COUNT));
	assign last_chunk = (chunk_q == CHUNK_CNT_W'(DIV_CHUNKS - 1));

	always_comb begin
		case (rem_q)
			2'd0:    new_trit = TRIT_ZERO;
			2'd1:    new_trit = TRIT_POS;
			default: new_trit = TRIT_NEG;
		endcase
	end

	always_comb begin
		if (single_q) emit_trit = TRIT_ZERO;
		else if (neg_q) emit_trit = ~trit_buf_q[rd_q] + 2'd1;
		else emit_trit = trit_buf_q[rd_q];
		emit_last = single_q || (rd_q == '0);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take && s_tlast && !acc.ignored) begin
					state_d = acc.bad ? ST_EMIT : ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = (work_zero || count_full) ? ST_EMIT : ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (last_chunk) state_d = ST_STORE;
			end
			ST_STORE: begin
				state_d = ST_CHECK;
			end
			ST_EMIT: begin
				if (out_load && emit_last) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_EMIT: out_load = !out_valid_q || m_tready;
			default: begin
				s_tready = 1'b0;
				out_load = 1'b0;
			end
		endcase
	end

	assign take = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			chunk_q     <= '0;
			rd_q        <= '0;
			single_q    <= 1'b0;
			err_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take && s_tlast) begin
						count_q  <= '0;
						single_q <= acc.bad;
						err_q    <= acc.bad;
					end
				end
				ST_CHECK: begin
					chunk_q <= '0;
					if (work_zero || count_full) begin
						// nothing converted means the value is zero: one zero digit
						if (count_q == '0) single_q <= 1'b1;
						rd_q <= IDX_W'(count_q - CNT_W'(1));
					end
				end
				ST_DIVIDE: begin
					chunk_q <= chunk_q + CHUNK_CNT_W'(1);
				end
				ST_STORE: begin
					count_q <= count_q + CNT_W'(1);
				end
				ST_EMIT: begin
					if (out_load && !emit_last) rd_q <= rd_q - IDX_W'(1);
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (take && s_tlast) begin
					work_q <= acc.mag;
					neg_q  <= acc.neg;
				end
			end
			ST_CHECK: begin
				rem_q <= 2'd0;
			end
			ST_DIVIDE: begin
				// shift the quotient in behind the dividend
				work_q <= {work_q[MAG_W-CHUNK_W-1:0], quo};
				rem_q  <= rem_nxt;
			end
			ST_STORE: begin
				trit_buf_q[count_q[IDX_W-1:0]] <= new_trit;
				// a remainder of 2 becomes digit -1 with a carry into the quotient
				work_q <= work_q + MAG_W'(rem_q == 2'd2);
			end
			default: begin
				work_q <= work_q;
			end
		endcase
		if (out_load) begin
			out_trit_q   <= emit_trit;
			out_status_q <= err_q;
			out_last_q   <= emit_last;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = {6'b000000, out_trit_q};
	assign m_tuser[0] = out_status_q;
	assign m_tlast    = out_last_q;

endmodule

`default_nettype wire

FILE: sv/dbt_checker.sv
// Port-level checks for the converter, bound to the top level.
// Depends on dbt_pkg and decimal_to_balanced_ternary_unit.
`default_nettype none

module dbt_checker import dbt_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       s_tlast,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic [0:0] m_tuser,
	input wire logic       m_tlast
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// characters before the final one never stall the input
	a_char_stream: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tlast |=> s_tready)
		else $error("input stalled inside a number");

	// an error is a single zero result that closes the run
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[1:0] == TRIT_ZERO && m_tlast)
		else $error("malformed error result");

	a_trit_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'b10 && m_tdata[7:2] == 6'b000000)
		else $error("illegal trit code");

endmodule

bind decimal_to_balanced_ternary_unit dbt_checker u_dbt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire

FILE: bench/decimal_to_balanced_ternary_unit_test.sv
// Self-checking bench for decimal_to_balanced_ternary_unit: decimal text goes in as
// stream transfers, and every trit that comes out is compared with a local predictor.
// Depends on dbt_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module decimal_to_balanced_ternary_unit_test;
	import dbt_pkg::*;

	// (3^25 - 1) / 2, the largest value that 25 balanced trits hold; below 2^40 - 1
	localparam logic [63:0] TERNARY_LIMIT  = 64'd423644304721;
	localparam int          DIRECTED_ROWS  = 24;
	localparam int          PHASE_ITEMS    = 45;
	localparam int          HOLDOFF_CYCLES = 600;
	localparam int          DRAIN_CYCLES   = 250;
	localparam int          QUIET_LIMIT    = 4000;

	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_GIVES_NONE,
		ROW_GIVES_ONE
	} row_kind_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
		row_kind_t  kind;
		logic [1:0] trit;
		logic       status;
	} stim_row_t;

	typedef struct packed {
		logic [1:0] trit;
		logic       status;
		logic       run_end;
	} trit_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [0:0] m_tuser;
	logic       m_tlast;

	// number being read, as the block should hold it
	logic [39:0] num_mag = '0;
	logic        num_neg = 1'b0;
	logic        num_bad = 1'b0;
	logic        num_started = 1'b0;
	logic        num_zero_lead = 1'b0;
	logic        num_ignored = 1'b0;

	trit_result_t fresh_trits [$];
	trit_result_t awaited_trits [$];
	logic [7:0]   char_plan [$];

	int chars_sent = 0;
	int fail_count = 0;
	int send_idle_pct = 0;
	int take_stall_pct = 0;
	int holdoff_asks = 0;
	int holdoff_served = 0;
	int holdoff_left = 0;
	int quiet_cycles = 0;

	int phase_send_idle [4] = '{0, 82, 0, 28};
	int phase_take_stall [4] = '{0, 0, 82, 28};

	stim_row_t directed_stim [DIRECTED_ROWS] = '{
		'{CHAR_ZERO, 1'b1, ROW_GIVES_ONE, TRIT_ZERO, 1'b0},   // lone zero
		'{CHAR_MINUS, 1'b1, ROW_GIVES_ONE, TRIT_ZERO, 1'b0},  // lone minus
		'{CHAR_MINUS, 1'b0, ROW_PREDICT, TRIT_ZERO, 1'b0},
		'{CHAR_ZERO, 1'b1, ROW_GIVES_ONE, TRIT_ZERO, 1'b0},   // minus zero
		'{CHAR_ZERO, 1'b0, ROW_PREDICT, TRIT_ZERO, 1'b0},
		'{8'h80, 1'b1, ROW_GIVES_ONE, TRIT_ZERO, 1'b0},       // junk after leading zero
		'{CHAR_ONE, 1'b1, ROW_PREDICT, TRIT_ZERO, 1'b0},
		'{8'hFF, 1'b1, ROW_GIVES_ONE, TRIT_ZERO, 1'b1},       // leading char above nine
		'{8'h00, 1'b1, ROW_GIVES_NONE, TRIT_ZERO, 1'b0},      // leading control char
		'{CHAR_NINE, 1'b0, ROW_PREDICT, TRIT_ZERO, 1'b0},
		'{"/", 1'b1, ROW_GIVES_ONE, TRIT_ZERO, 1'b1},         // later char below zero
		'{CHAR_MINUS, 1'b0, ROW_PREDICT, TRIT_ZERO, 1'b0},    // most negative value
		'{"4", 1'b0, ROW_PREDICT, TRIT_ZERO, 1'b0},
		'{"2", 1'b0, ROW_PREDICT, TRIT_ZERO, 1'b0},
		'{"3", 1'b0, ROW_PREDICT, TRIT_ZERO, 1'b0},
		'{"6", 1'b0, ROW_PREDICT, TRIT_ZERO, 1'b0},
		'{"4", 1'b0, ROW_PREDICT, TRIT_ZERO, 1'b0},
		'{"4", 1'b0, ROW_PREDICT, TRIT_ZERO, 1'b0},
		'{"3", 1'b0, ROW_PREDICT, TRIT_ZERO, 1'b0},
		'{"0", 1'b0, ROW_PREDICT, TRIT_ZERO, 1'b0},
		'{"4", 1'b0, ROW_PREDICT, TRIT_ZERO, 1'b0},
		'{"7", 1'b0, ROW_PREDICT, TRIT_ZERO, 1'b0},
		'{"2", 1'b0, ROW_PREDICT, TRIT_ZERO, 1'b0},
		'{"1", 1'b1, ROW_PREDICT, TRIT_ZERO, 1'b0}
	};

	decimal_to_balanced_ternary_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void add_decimal_digit(input logic [7:0] ch);
		logic [63:0] d;
		d = 64'(ch - CHAR_ZERO);
		if (num_bad)
			return;
		// flag overflow instead of wrapping
		if ({24'd0, num_mag} > (TERNARY_LIMIT - d) / 64'd10)
			num_bad = 1'b1;
		else
			num_mag = 40'({24'd0, num_mag} * 64'd10 + d);
	endfunction

	// Apply one character to the number; on the final one, queue its trits in fresh_trits.
	task automatic absorb_char(input logic [7:0] ch, input logic fin, output bit counted);
		logic [63:0] rest;
		logic [1:0]  trits [TRIT_COUNT];
		logic [1:0]  t;
		int          n;
		counted = !(num_started && (num_zero_lead || num_ignored));
		if (!num_started) begin
			num_started = 1'b1;
			if (ch == CHAR_MINUS) begin
				num_neg = 1'b1;
			end else if (ch == CHAR_ZERO) begin
				num_zero_lead = 1'b1;
			end else if (ch >= CHAR_ONE && ch <= CHAR_NINE) begin
				add_decimal_digit(ch);
			end else if (ch > CHAR_NINE) begin
				num_bad = 1'b1;
			end else begin
				num_ignored = 1'b1;
				counted = 1'b0;
			end
		end else if (!num_zero_lead && !num_ignored) begin
			if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
				add_decimal_digit(ch);
			else
				num_bad = 1'b1;
		end
		if (!fin)
			return;
		if (num_ignored) begin
			// drop the whole number silently
		end else if (num_bad) begin
			fresh_trits.push_back('{TRIT_ZERO, 1'b1, 1'b1});
		end else if (num_zero_lead || num_mag == 0) begin
			fresh_trits.push_back('{TRIT_ZERO, 1'b0, 1'b1});
		end else begin
			rest = {24'd0, num_mag};
			n = 0;
			while (rest != 0 && n < TRIT_COUNT) begin
				case (rest % 3)
					64'd0: trits[n] = TRIT_ZERO;
					64'd1: trits[n] = TRIT_POS;
					default: trits[n] = TRIT_NEG;
				endcase
				rest = rest / 3;
				if (trits[n] == TRIT_NEG)
					rest = rest + 1;
				n++;
			end
			for (int k = n - 1; k >= 0; k--) begin
				t = trits[k];
				if (num_neg)
					t = (t == TRIT_POS) ? TRIT_NEG : (t == TRIT_NEG) ? TRIT_POS : TRIT_ZERO;
				fresh_trits.push_back('{t, 1'b0, k == 0});
			end
		end
		num_mag = '0;
		num_neg = 1'b0;
		num_bad = 1'b0;
		num_started = 1'b0;
		num_zero_lead = 1'b0;
		num_ignored = 1'b0;
	endtask

	// Offer one character, wait for the transfer, then record what it should produce.
	task automatic send_char(input logic [7:0] ch, input logic fin, input row_kind_t kind,
			input logic [1:0] trit, input logic status);
		bit counted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ch;
		s_tlast <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		absorb_char(ch, fin, counted);
		if (counted)
			chars_sent++;
		if (kind != ROW_PREDICT) begin
			fresh_trits.delete();
			if (kind == ROW_GIVES_ONE)
				fresh_trits.push_back('{trit, status, 1'b1});
		end
		awaited_trits = {awaited_trits, fresh_trits};
		fresh_trits.delete();
	endtask

	task automatic send_plan();
		for (int i = 0; i < char_plan.size(); i++)
			send_char(char_plan[i], i == char_plan.size() - 1, ROW_PREDICT, TRIT_ZERO, 1'b0);
		char_plan.delete();
	endtask

	task automatic plan_decimal(input logic [63:0] v);
		logic [7:0] digs [$];
		do begin
			digs.push_front(8'(CHAR_ZERO + v % 10));
			v = v / 10;
		end while (v != 0);
		char_plan = {char_plan, digs};
	endtask

	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 64'($urandom_range(1, 99));
			4, 5: return 64'($urandom_range(100, 999999));
			6: return 64'($urandom_range(1000000, 32'hFFFF_FFFF));
			7: return TERNARY_LIMIT - 64'd20 + 64'($urandom_range(0, 40));  // range edge
			8: return {32'd0, $urandom} * 64'd10000 + 64'($urandom_range(0, 9999));
			default: return 64'($urandom_range(1, 9));
		endcase
	endfunction

	task automatic send_random_number();
		int         pick;
		int         pos;
		logic [7:0] junk;
		pick = $urandom_range(0, 99);
		if (pick < 80 && !(pick >= 55 && pick < 65)) begin
			if ($urandom_range(0, 1))
				char_plan.push_back(CHAR_MINUS);
			plan_decimal(pick < 55 ? pick_value() : 64'($urandom_range(1, 99999)));
			if (pick >= 65) begin
				// break the number with one non-digit somewhere after its start
				do
					junk = 8'($urandom_range(0, 255));
				while (junk >= CHAR_ZERO && junk <= CHAR_NINE);
				pos = $urandom_range(1, char_plan.size());
				char_plan.insert(pos, junk);
			end
		end else if (pick < 65) begin
			char_plan.push_back(CHAR_ZERO);
			repeat ($urandom_range(0, 3))
				char_plan.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 3))
				char_plan.push_back(8'($urandom_range(0, 255)));
		end
		send_plan();
	endtask

	// Hold the input quiet until every awaited trit has been taken.
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (awaited_trits.size() != 0);
	endtask

	task automatic check_trit();
		trit_result_t want;
		if (awaited_trits.size() == 0) begin
			$error("unexpected transfer: tdata %h tuser %b tlast %b", m_tdata, m_tuser, m_tlast);
			fail_count++;
			return;
		end
		want = awaited_trits.pop_front();
		if (m_tdata[1:0] !== want.trit) begin
			$error("trit: expected %0d, actual %0d", $signed(want.trit), $signed(m_tdata[1:0]));
			fail_count++;
		end
		if (m_tdata[7:2] !== 6'd0) begin
			$error("tdata padding: expected 0, actual %h", m_tdata[7:2]);
			fail_count++;
		end
		if (m_tuser[0] !== want.status) begin
			$error("status: expected %b, actual %b", want.status, m_tuser[0]);
			fail_count++;
		end
		if (m_tlast !== want.run_end) begin
			$error("run_end: expected %b, actual %b", want.run_end, m_tlast);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				check_trit();
			if (holdoff_asks != holdoff_served) begin
				holdoff_served = holdoff_asks;
				holdoff_left = HOLDOFF_CYCLES;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= take_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("decimal_to_balanced_ternary_unit_test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int goal;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_char(directed_stim[i].ch, directed_stim[i].fin, directed_stim[i].kind,
				directed_stim[i].trit, directed_stim[i].status);
		wait_drain();

		goal = chars_sent;
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = phase_send_idle[p];
			take_stall_pct = phase_take_stall[p];
			goal += PHASE_ITEMS;
			while (chars_sent < goal) begin
				send_random_number();
				if ($urandom_range(0, 19) == 0)
					wait_drain();
			end
			wait_drain();
		end

		// stall the output for a long stretch while full-length numbers keep coming
		send_idle_pct = 0;
		take_stall_pct = 0;
		holdoff_asks++;
		repeat (3) begin
			plan_decimal(TERNARY_LIMIT - 64'($urandom_range(0, 1000)));
			send_plan();
		end
		wait_drain();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && awaited_trits.size() == 0)
			$display("decimal_to_balanced_ternary_unit_test passed");
		else
			$display("decimal_to_balanced_ternary_unit_test failed");
		$finish;
	end

endmodule

FILE: files.f
sv/dbt_pkg.sv
sv/dbt_accum.sv
sv/dbt_div3.sv
sv/decimal_to_balanced_ternary_unit.sv
sv/dbt_checker.sv
bench/decimal_to_balanced_ternary_unit_test.sv
